[hw/rtl/ipbs_pkg.sv]
// shared types and constants for the interpolation pre-pass bubble sorter
`default_nettype none

package ipbs_pkg;

    // element and result widths
    localparam int VALUE_W        = 16;
    localparam int TALLY_W        = 11;
    localparam int PASSES_W       = 8;
    localparam int MAX_ELEMENTS_DEF = 16;

    // configuration port layout
    localparam int APB_DATA_W     = 32;
    localparam int PADDR_W        = 3;
    localparam logic [PADDR_W-3:0] REG_SCRAMBLE_PASSES = 1'b0;

    // saturation limit of the swap tally
    localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SC_RDI,
        S_SC_MUL,
        S_SC_DIV,
        S_SC_RDJ,
        S_SC_CMP,
        S_SC_WRJ,
        S_BB_RD,
        S_BB_CMP,
        S_BB_WR,
        S_OUT
    } ipbs_state_t;

endpackage

`default_nettype wire

[hw/rtl/interpolation_prepass_bubble_sorter_unit.sv]
// interpolation pre-pass bubble sorter: loader, scramble and bubble sequencer, output
//
//  channel   direction  handshake                    payload
//  -------   ---------  ---------------------------  ----------------------------------
//  request   in         start high while busy low    value, last
//  result    out        result_valid, one cycle each  sorted_value, swap_count, last_out
//  config    in         psel/penable/pwrite, pready  paddr, pwdata (prdata on read)
//
//  a request not marked last is taken and busy stays low.
//  a last request starts the sort; one element store with two read ports and one
//  write port does all the work; a scramble step reads element i, multiplies,
//  divides (skipped when all values are equal), reads element q, compares and, on a
//  swap, writes both back, the divider taking one quotient bit per cycle.
//  a scramble pass is n steps, up to scramble_passes passes, stopping after a pass
//  without swaps; a bubble compare reads a pair and writes it back on a swap, at
//  most n passes of n - 1 compares, stopping after a clean pass; then n results,
//  one per cycle. no clearing pass after reset; the receiver cannot stall results.
`default_nettype none

module interpolation_prepass_bubble_sorter_unit #(
    parameter int MAX_ELEMENTS = ipbs_pkg::MAX_ELEMENTS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // request channel
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic signed [ipbs_pkg::VALUE_W-1:0]    value,
    input  wire logic                                   last,
    // result channel
    output logic                                        result_valid,
    output logic signed [ipbs_pkg::VALUE_W-1:0]         sorted_value,
    output logic        [ipbs_pkg::TALLY_W-1:0]         swap_count,
    output logic                                        last_out,
    // configuration port
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic   [ipbs_pkg::PADDR_W-1:0]         paddr,
    input  wire logic   [ipbs_pkg::APB_DATA_W-1:0]      pwdata,
    output logic        [ipbs_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                        pready
);

    import ipbs_pkg::*;

    localparam int IDX_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int PROD_W = VALUE_W + IDX_W;
    localparam int DCNT_W = $clog2(IDX_W + 1);

    // control registers
    ipbs_state_t                 state_reg, state_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic signed [VALUE_W-1:0]   min_reg, min_next;
    logic signed [VALUE_W-1:0]   max_reg, max_next;
    logic [PASSES_W-1:0]         passes_reg;
    logic [PASSES_W-1:0]         pass_reg, pass_next;
    logic [IDX_W-1:0]            i_reg, i_next;
    logic [IDX_W-1:0]            k_reg, k_next;
    logic [IDX_W-1:0]            nm1_reg, nm1_next;
    logic [DCNT_W-1:0]           div_cnt_reg, div_cnt_next;
    logic                        swapped_reg, swapped_next;
    logic [TALLY_W-1:0]          tally_reg, tally_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_last_reg, out_last_next;

    // payload registers
    logic signed [VALUE_W-1:0]   v_reg, v_next;
    logic [PROD_W-1:0]           rem_reg, rem_next;
    logic [PROD_W-1:0]           dvs_reg, dvs_next;
    logic [IDX_W-1:0]            q_reg, q_next;

    // element store
    logic signed [VALUE_W-1:0]   store_mem [MAX_ELEMENTS];
    logic signed [VALUE_W-1:0]   rd_a_reg, rd_b_reg;
    logic                        mem_we;
    logic [IDX_W-1:0]            mem_waddr;
    logic signed [VALUE_W-1:0]   mem_wdata;
    logic                        rd_en;
    logic [IDX_W-1:0]            raddr_a, raddr_b;

    // datapath helpers
    logic                        accept;
    logic [CNT_W-1:0]            count_load;
    logic [VALUE_W:0]            diff_wide, span_wide;
    logic [VALUE_W-1:0]          diff_u, span_u;
    logic                        span_zero;
    logic                        div_ge;
    logic                        sc_swap, bb_swap;
    logic                        sc_adv, bb_adv, bb_start;
    logic [IDX_W-1:0]            k_end;
    logic                        cfg_wr;

    assign accept    = start && !busy;
    assign diff_wide = {rd_a_reg[VALUE_W-1], rd_a_reg} - {min_reg[VALUE_W-1], min_reg};
    assign span_wide = {max_reg[VALUE_W-1], max_reg} - {min_reg[VALUE_W-1], min_reg};
    assign diff_u    = diff_wide[VALUE_W-1:0];
    assign span_u    = span_wide[VALUE_W-1:0];
    assign span_zero = (max_reg == min_reg);
    assign div_ge    = (rem_reg >= dvs_reg);
    assign sc_swap   = ((i_reg > q_reg) && (v_reg > rd_a_reg)) || (v_reg < rd_a_reg);
    assign bb_swap   = (rd_a_reg > rd_b_reg);
    assign k_end     = IDX_W'(nm1_reg - 1'b1);

    // sequencer: next state, counters and store access
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        pass_next      = pass_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        nm1_next       = nm1_reg;
        div_cnt_next   = div_cnt_reg;
        swapped_next   = swapped_reg;
        tally_next     = tally_reg;
        out_valid_next = 1'b0;
        out_last_next  = 1'b0;
        v_next         = v_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        q_next         = q_reg;
        mem_we         = 1'b0;
        mem_waddr      = i_reg;
        mem_wdata      = value;
        rd_en          = 1'b0;
        raddr_a        = i_reg;
        raddr_b        = k_reg;
        sc_adv         = 1'b0;
        bb_adv         = 1'b0;
        bb_start       = 1'b0;
        count_load     = count_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (count_reg < CNT_W'(MAX_ELEMENTS))
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = count_reg[IDX_W-1:0];
                        mem_wdata  = value;
                        count_load = CNT_W'(count_reg + 1'b1);
                        if ((count_reg == '0) || (value < min_reg))
                        begin
                            min_next = value;
                        end
                        if ((count_reg == '0) || (value > max_reg))
                        begin
                            max_next = value;
                        end
                    end
                    count_next = count_load;
                    if (last)
                    begin
                        nm1_next = IDX_W'(count_load - 1'b1);
                        if (passes_reg != '0)
                        begin
                            state_next   = S_SC_RDI;
                            pass_next    = '0;
                            i_next       = '0;
                            swapped_next = 1'b0;
                        end
                        else
                        begin
                            bb_start = 1'b1;
                        end
                    end
                end
            end

            S_SC_RDI:
            begin
                rd_en      = 1'b1;
                raddr_a    = i_reg;
                state_next = S_SC_MUL;
            end

            S_SC_MUL:
            begin
                // offset times (n - 1), divisor aligned to the top quotient bit
                v_next       = rd_a_reg;
                rem_next     = PROD_W'(diff_u) * PROD_W'(nm1_reg);
                dvs_next     = PROD_W'(span_u) << (IDX_W - 1);
                q_next       = '0;
                div_cnt_next = DCNT_W'(IDX_W);
                state_next   = span_zero ? S_SC_RDJ : S_SC_DIV;
            end

            S_SC_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (div_ge)
                begin
                    rem_next = rem_reg - dvs_reg;
                end
                dvs_next     = dvs_reg >> 1;
                q_next       = IDX_W'({q_reg, div_ge});
                div_cnt_next = DCNT_W'(div_cnt_reg - 1'b1);
                if (div_cnt_reg == DCNT_W'(1))
                begin
                    state_next = S_SC_RDJ;
                end
            end

            S_SC_RDJ:
            begin
                rd_en      = 1'b1;
                raddr_a    = q_reg;
                state_next = S_SC_CMP;
            end

            S_SC_CMP:
            begin
                if (sc_swap)
                begin
                    mem_we       = 1'b1;
                    mem_waddr    = i_reg;
                    mem_wdata    = rd_a_reg;
                    swapped_next = 1'b1;
                    state_next   = S_SC_WRJ;
                end
                else
                begin
                    sc_adv = 1'b1;
                end
            end

            S_SC_WRJ:
            begin
                mem_we    = 1'b1;
                mem_waddr = q_reg;
                mem_wdata = v_reg;
                sc_adv    = 1'b1;
            end

            S_BB_RD:
            begin
                if (nm1_reg == '0)
                begin
                    k_next     = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    raddr_a    = k_reg;
                    raddr_b    = IDX_W'(k_reg + 1'b1);
                    state_next = S_BB_CMP;
                end
            end

            S_BB_CMP:
            begin
                if (bb_swap)
                begin
                    mem_we       = 1'b1;
                    mem_waddr    = k_reg;
                    mem_wdata    = rd_b_reg;
                    swapped_next = 1'b1;
                    if (tally_reg != TALLY_MAX)
                    begin
                        tally_next = TALLY_W'(tally_reg + 1'b1);
                    end
                    state_next = S_BB_WR;
                end
                else
                begin
                    bb_adv = 1'b1;
                end
            end

            S_BB_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = IDX_W'(k_reg + 1'b1);
                mem_wdata = rd_a_reg;
                bb_adv    = 1'b1;
            end

            S_OUT:
            begin
                // one read per cycle, result shows the cycle after
                rd_en          = 1'b1;
                raddr_a        = k_reg;
                out_valid_next = 1'b1;
                out_last_next  = (k_reg == nm1_reg);
                if (k_reg == nm1_reg)
                begin
                    count_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next = IDX_W'(k_reg + 1'b1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // next scramble element, pass or hand over to the bubble sort
        if (sc_adv)
        begin
            if (i_reg == nm1_reg)
            begin
                if (!swapped_next ||
                    ({1'b0, pass_reg} + 1'b1 == {1'b0, passes_reg}))
                begin
                    bb_start = 1'b1;
                end
                else
                begin
                    pass_next    = PASSES_W'(pass_reg + 1'b1);
                    i_next       = '0;
                    swapped_next = 1'b0;
                    state_next   = S_SC_RDI;
                end
            end
            else
            begin
                i_next     = IDX_W'(i_reg + 1'b1);
                state_next = S_SC_RDI;
            end
        end

        // next bubble compare; a clean pass ends the sort
        if (bb_adv)
        begin
            if (k_reg == k_end)
            begin
                k_next       = '0;
                state_next   = swapped_next ? S_BB_RD : S_OUT;
                swapped_next = 1'b0;
            end
            else
            begin
                k_next     = IDX_W'(k_reg + 1'b1);
                state_next = S_BB_RD;
            end
        end

        if (bb_start)
        begin
            tally_next   = '0;
            k_next       = '0;
            swapped_next = 1'b0;
            state_next   = S_BB_RD;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            min_reg       <= '0;
            max_reg       <= '0;
            pass_reg      <= '0;
            i_reg         <= '0;
            k_reg         <= '0;
            nm1_reg       <= '0;
            div_cnt_reg   <= '0;
            swapped_reg   <= 1'b0;
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            pass_reg      <= pass_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            nm1_reg       <= nm1_next;
            div_cnt_reg   <= div_cnt_next;
            swapped_reg   <= swapped_next;
            tally_reg     <= tally_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    // divider and compare operands
    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
    end

    // element store, one write port and two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_a_reg <= store_mem[raddr_a];
            rd_b_reg <= store_mem[raddr_b];
        end
    end

    // configuration register
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            passes_reg <= '0;
        end
        else if (cfg_wr && (paddr[PADDR_W-1:2] == REG_SCRAMBLE_PASSES))
        begin
            passes_reg <= pwdata[PASSES_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1:2] == REG_SCRAMBLE_PASSES) ?
                    APB_DATA_W'(passes_reg) : '0;

    // outputs
    assign busy         = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign sorted_value = rd_a_reg;
    assign swap_count   = tally_reg;
    assign last_out     = out_last_reg;

`ifndef NO_ASSERTIONS
    // nothing follows the final result of a run
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_out |=> !result_valid)
        else $error("result after final element of run");

    // a request not marked last never starts the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !last |=> !busy)
        else $error("sequencer started without a last request");

    // results only come out of a running sort
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result while idle");

    // results of a run are back to back and carry one swap count
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_out |=> result_valid && $stable(swap_count))
        else $error("gap or count change inside a run");
`endif

endmodule

`default_nettype wire
